### hw/rtl/ttnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnf_pkg
// shared constants, types and constant tables of the note to frequency core
// ----------------------------------------------------------------------------
package ttnf_pkg;

  localparam int LOG_FRAC        = 24;  // fraction bits of the log domain
  localparam int LOG_W           = 30;  // signed log: 6 integer, 24 fraction
  localparam int LT_W            = 34;  // interpolated log incl. octave
  localparam int K_W             = LT_W - LOG_FRAC;
  localparam int SH_W            = 11;  // signed output scale
  localparam int FREQ_W          = 48;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam logic [6:0] TLEN_RESET = 7'd13;

  localparam int LOG_LAT = LOG_FRAC + 1;  // normalize plus one squaring per bit
  localparam int EXP_LAT = LOG_FRAC;      // one factor per bit

  typedef logic [LOG_FRAC:0][31:0] fac_tab_t;

  // integer square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // q1.31: 1.0 at 0, else 2^(2^-j), truncated root of 2 or of the one before
  function automatic fac_tab_t exp_factors();
    fac_tab_t   t;
    logic [63:0] c;
    t    = '0;
    c    = 64'h1_0000_0000;
    t[0] = 32'h8000_0000;
    for (int j = 1; j <= LOG_FRAC; j++) begin
      c    = isqrt64(c << 31);
      t[j] = c[31:0];
    end
    return t;
  endfunction

  localparam fac_tab_t EXP_C = exp_factors();

  // data riding beside the log and exp pipes
  typedef struct packed {
    logic               last;
    logic               exact;
    logic               zero;
    logic [31:0]        root;
    logic [31:0]        ratio_a;
    logic signed [7:0]  oct;
    logic [15:0]        r;
    logic signed [K_W-1:0] k;
  } side_t;

endpackage

### hw/rtl/ttnf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnf_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ttnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ttnf_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnf_log2
// pipelined log2 of a q2.30 ratio, one squaring stage per fraction bit
// ----------------------------------------------------------------------------
module ttnf_log2 (
  input  logic                                clk,
  input  logic                                ce,
  input  logic [31:0]                         x,
  output logic signed [ttnf_pkg::LOG_W-1:0]   log_out
);

  localparam int NF = ttnf_pkg::LOG_FRAC;

  logic [4:0]          p;
  logic [31:0]         y_q  [0:NF];
  logic [NF-1:0]       fr_q [0:NF];
  logic signed [5:0]   pm_q [0:NF];
  logic [63:0]         sq   [1:NF];

  // msb position
  always_comb begin
    p = '0;
    for (int n = 0; n < 32; n++) begin
      if (x[n]) p = 5'(n);
    end
  end

  always_comb begin
    for (int n = 1; n <= NF; n++) begin
      sq[n] = 64'(y_q[n-1]) * 64'(y_q[n-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      y_q[0]  <= x << (5'd31 - p);
      fr_q[0] <= '0;
      pm_q[0] <= $signed({1'b0, p}) - 6'sd30;
      for (int n = 1; n <= NF; n++) begin
        pm_q[n] <= pm_q[n-1];
        if (sq[n][63]) begin
          y_q[n]  <= sq[n][63:32];
          fr_q[n] <= fr_q[n-1] | (NF'(1) << (NF - n));
        end else begin
          y_q[n]  <= sq[n][62:31];
          fr_q[n] <= fr_q[n-1];
        end
      end
    end
  end

  assign log_out = {pm_q[NF], fr_q[NF]};

endmodule

### hw/rtl/ttnf_exp2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnf_exp2
// pipelined 2^f for a 24 bit fraction, q1.31 result, one factor per stage
// ----------------------------------------------------------------------------
module ttnf_exp2 (
  input  logic                             clk,
  input  logic                             ce,
  input  logic [ttnf_pkg::LOG_FRAC-1:0]    f,
  output logic [31:0]                      m
);

  localparam int NF = ttnf_pkg::LOG_FRAC;

  logic [31:0]   m_q  [1:NF];
  logic [NF-1:0] f_q  [1:NF-1];
  logic [31:0]   m_in [1:NF];
  logic [NF-1:0] f_in [1:NF];
  logic [63:0]   prd  [1:NF];

  always_comb begin
    m_in[1] = ttnf_pkg::EXP_C[0];
    f_in[1] = f;
    for (int n = 2; n <= NF; n++) begin
      m_in[n] = m_q[n-1];
      f_in[n] = f_q[n-1];
    end
    for (int n = 1; n <= NF; n++) begin
      prd[n] = 64'(m_in[n]) * 64'(ttnf_pkg::EXP_C[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int n = 1; n <= NF; n++) begin
        m_q[n] <= f_in[n][NF-n] ? prd[n][62:31] : m_in[n];
        if (n < NF) f_q[n] <= f_in[n];
      end
    end
  end

  assign m = m_q[NF];

endmodule

### hw/rtl/tuning_table_note_to_freq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuning_table_note_to_freq_core
// turns a pitch in octaves over a root frequency into a frequency through a
// loaded one-octave tuning table of ratios
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while the pipe is not held, and table
// writes give no result. A conversion passes through the table read, the
// two log2 pipes (one squaring multiplier per fraction bit, 24 stages plus a
// normalize stage), the interpolation stages, the exp2 pipe (one multiplier
// per fraction bit, 24 stages), the product register and the result
// register. The whole pipe advances together and holds while the result
// register is full and not taken. A table write takes effect for any item
// accepted after it. A table entry must be written before a conversion uses
// it; table_length below 2 acts as 2 and above MAX_ENTRIES as MAX_ENTRIES.
// ----------------------------------------------------------------------------
module tuning_table_note_to_freq_core #(
  parameter int MAX_ENTRIES = ttnf_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // table_length register
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // [23:0] note_octaves, [55:24] root_freq, [61:56] entry_index,
  // [93:62] entry_ratio, [95:94] zero
  input  logic [95:0] s_tdata,
  input  logic        s_tuser,   // [0] req_type
  input  logic        s_tlast,   // block_end
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [47:0] frequency
  output logic        m_tuser,   // [0] saturated
  output logic        m_tlast    // block_end_out
);

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int LL  = ttnf_pkg::LOG_LAT;
  localparam int EL  = ttnf_pkg::EXP_LAT;
  localparam int NF  = ttnf_pkg::LOG_FRAC;
  localparam int LW  = ttnf_pkg::LOG_W;
  localparam int TW  = ttnf_pkg::LT_W;
  localparam int SW  = ttnf_pkg::SH_W;
  localparam int FW  = ttnf_pkg::FREQ_W;

  // input fields
  logic               req_type;
  logic signed [23:0] note_octaves;
  logic [31:0]        root_freq;
  logic [5:0]         entry_index;
  logic [31:0]        entry_ratio;

  assign req_type     = s_tuser;
  assign note_octaves = $signed(s_tdata[23:0]);
  assign root_freq    = s_tdata[55:24];
  assign entry_index  = s_tdata[61:56];
  assign entry_ratio  = s_tdata[93:62];

  // whole pipe moves when the result register can take a new value
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  logic accept;
  assign accept = s_tvalid && s_tready;

  // table_length register
  logic [6:0] table_length;
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= ttnf_pkg::TLEN_RESET;
    end else if (cfg_we) begin
      table_length <= cfg_wdata;
    end
  end

  // clamp length, split the fraction into entry index and remainder
  logic [31:0]    len_sel;
  logic [IW-1:0]  lenm1;
  logic [IW+15:0] q;
  logic [IW-1:0]  idx_i;
  logic [IW-1:0]  idx_j;

  always_comb begin
    if (table_length < 7'd2) begin
      len_sel = 32'd2;
    end else if (32'(table_length) > MAX_ENTRIES) begin
      len_sel = 32'(MAX_ENTRIES);
    end else begin
      len_sel = 32'(table_length);
    end
  end

  assign lenm1 = IW'(len_sel - 32'd1);
  assign q     = (IW+16)'(note_octaves[15:0]) * (IW+16)'(lenm1);
  assign idx_i = q[IW+15:16];
  assign idx_j = idx_i + IW'(1);

  // ratio table, one copy per read address
  logic          tbl_we;
  logic [31:0]   rd_a;
  logic [31:0]   rd_b;

  assign tbl_we = accept && req_type && (32'(entry_index) < MAX_ENTRIES);

  ttnf_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_tbl_a (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IW'(entry_index)),
    .wdata (entry_ratio),
    .re    (ce),
    .raddr (idx_i),
    .rdata (rd_a)
  );

  ttnf_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_tbl_b (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IW'(entry_index)),
    .wdata (entry_ratio),
    .re    (ce),
    .raddr (idx_j),
    .rdata (rd_b)
  );

  // stage 1: beside the table read
  logic             v1;
  ttnf_pkg::side_t  sd1;
  ttnf_pkg::side_t  sd0;

  always_ff @(posedge clk) begin
    if (ce) begin
      sd1.last    <= s_tlast;
      sd1.exact   <= (q[15:0] == 16'd0);
      sd1.zero    <= 1'b0;
      sd1.root    <= root_freq;
      sd1.ratio_a <= '0;
      sd1.oct     <= note_octaves[23:16];
      sd1.r       <= q[15:0];
      sd1.k       <= '0;
    end
  end

  // ratio a and the zero-entry case only known once the table is read
  always_comb begin
    sd0         = sd1;
    sd0.ratio_a = rd_a;
    sd0.zero    = (rd_a == 32'd0) || (rd_b == 32'd0);
  end

  // log2 of both neighboring entries
  logic signed [LW-1:0] la;
  logic signed [LW-1:0] lb;

  ttnf_log2 u_log_a (.clk(clk), .ce(ce), .x(rd_a), .log_out(la));
  ttnf_log2 u_log_b (.clk(clk), .ce(ce), .x(rd_b), .log_out(lb));

  ttnf_pkg::side_t sd_l [1:LL];
  logic [LL:1]     v_l;

  // interpolation stages
  ttnf_pkg::side_t      sd_i1;
  ttnf_pkg::side_t      sd_i1k;
  ttnf_pkg::side_t      sd_i2;
  logic                 v_i1;
  logic                 v_i2;
  logic signed [LW-1:0] la_i1;
  logic signed [47:0]   dr_i1;
  logic signed [LW:0]   diff;
  logic signed [TW-1:0] lt;
  logic [NF-1:0]        f_i2;

  assign diff = (LW+1)'(lb) - (LW+1)'(la);
  assign lt   = TW'(la_i1) + TW'(dr_i1 >>> 16) + (TW'(sd_i1.oct) <<< NF);

  // side data with the integer part of the log filled in
  always_comb begin
    sd_i1k   = sd_i1;
    sd_i1k.k = lt[TW-1:NF];
  end

  // exp2 of the fraction
  logic [31:0]     mant;
  ttnf_pkg::side_t sd_e [1:EL];
  logic [EL:1]     v_e;

  ttnf_exp2 u_exp (.clk(clk), .ce(ce), .f(f_i2), .m(mant));

  // final product and output scaling
  logic                 v_f1;
  logic [63:0]          prod_q;
  logic signed [SW-1:0] s_q;
  logic                 last_f1;
  logic [31:0]          opnd;
  logic signed [SW-1:0] s_next;
  logic                 zero_next;

  always_comb begin
    if (sd_e[EL].exact) begin
      opnd      = sd_e[EL].ratio_a;
      s_next    = SW'(sd_e[EL].oct);
      s_next    = 11'sd30 - s_next;
      zero_next = 1'b0;
    end else begin
      opnd      = mant;
      s_next    = SW'(sd_e[EL].k);
      s_next    = 11'sd31 - s_next;
      zero_next = sd_e[EL].zero;
    end
  end

  // shift by the scale, saturate or flush
  logic [63:0]          shv;
  logic signed [SW-1:0] neg;
  logic [5:0]           hsh;
  logic [FW-1:0]        freq_next;
  logic                 sat_next;

  always_comb begin
    freq_next = '0;
    sat_next  = 1'b0;
    shv       = '0;
    neg       = -s_q;
    hsh       = '0;
    if (prod_q == 64'd0 || s_q >= 11'sd64) begin
      freq_next = '0;
    end else if (s_q >= 11'sd0) begin
      shv = prod_q >> s_q[5:0];
      if (|shv[63:FW]) begin
        sat_next  = 1'b1;
        freq_next = '1;
      end else begin
        freq_next = shv[FW-1:0];
      end
    end else if (neg >= 11'sd48) begin
      sat_next  = 1'b1;
      freq_next = '1;
    end else begin
      hsh = 6'd48 - neg[5:0];
      shv = prod_q >> hsh;
      if (shv != 64'd0) begin
        sat_next  = 1'b1;
        freq_next = '1;
      end else begin
        freq_next = FW'(prod_q << neg[5:0]);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ce) begin
      sd_l[1] <= sd0;
      for (int n = 2; n <= LL; n++) begin
        sd_l[n] <= sd_l[n-1];
      end

      sd_i1 <= sd_l[LL];
      la_i1 <= la;
      dr_i1 <= 48'(diff) * 48'($signed({1'b0, sd_l[LL].r}));

      sd_i2   <= sd_i1k;
      f_i2    <= lt[NF-1:0];

      sd_e[1] <= sd_i2;
      for (int n = 2; n <= EL; n++) begin
        sd_e[n] <= sd_e[n-1];
      end

      prod_q  <= zero_next ? 64'd0 : 64'(sd_e[EL].root) * 64'(opnd);
      s_q     <= s_next;
      last_f1 <= sd_e[EL].last;

      m_tdata <= freq_next;
      m_tuser <= sat_next;
      m_tlast <= last_f1;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v_l      <= '0;
      v_i1     <= 1'b0;
      v_i2     <= 1'b0;
      v_e      <= '0;
      v_f1     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      v1       <= accept && !req_type;
      v_l      <= {v_l[LL-1:1], v1};
      v_i1     <= v_l[LL];
      v_i2     <= v_i1;
      v_e      <= {v_e[EL-1:1], v_i2};
      v_f1     <= v_e[EL];
      m_tvalid <= v_f1;
    end
  end

endmodule
